>>> src/assert_macros.svh
// Assertion macros used by the converter's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define H2R_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define H2R_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define H2R_ASSERT(label, prop, msg)
`define H2R_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> src/h2r_pkg.sv
// Types, constants and the hue ratio table of the HSI to RGB converter.
package h2r_pkg;

  localparam int FRAC_BITS = 14;
  localparam int RATIO_W   = FRAC_BITS + 3;
  localparam int PROD_W    = RATIO_W + 9;
  localparam int NS_W      = FRAC_BITS + 12;
  localparam int N_W       = FRAC_BITS + 10;
  localparam int SCALE_W   = N_W + 8;
  localparam int X_W       = 18;
  localparam int DIV_SHIFT = 28;
  localparam int M_W       = 19;
  localparam logic [M_W-1:0] DIV_MUL   = M_W'(350897);
  localparam logic [X_W-1:0] SAT_LIMIT = X_W'(255 * 765);

  localparam logic [8:0] HUE_WRAP   = 9'd360;
  localparam logic [8:0] SECT_SPAN  = 9'd120;
  localparam logic [8:0] SECT_SPAN2 = 9'd240;
  localparam int         TAB_DEPTH  = 120;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] intensity;
  } hsi_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    sector_t    sector;
    logic       grey;
    logic [7:0] intensity;
  } side_t;

  typedef logic signed [RATIO_W-1:0] ratio_t;
  typedef ratio_t ratio_tab_t [TAB_DEPTH];

  function automatic logic signed [63:0] cos_q30(int deg);
    int                 a;
    logic               neg;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        pos;
    logic [63:0]        negsum;
    logic signed [63:0] v;
    a = (deg < 0) ? -deg : deg;
    neg = 1'b0;
    if (a > 90) begin
      a = 180 - a;
      neg = 1'b1;
    end
    x = (64'(a) * PI_Q30 + 64'd90) / 64'd180;
    x2 = (x * x) >> 30;
    term = ONE_Q30;
    pos = ONE_Q30;
    negsum = 64'd0;
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if ((k % 2) == 1) begin
        negsum = negsum + term;
      end else begin
        pos = pos + term;
      end
    end
    v = $signed(pos) - $signed(negsum);
    return neg ? -v : v;
  endfunction

  function automatic ratio_tab_t build_ratio_tab();
    ratio_tab_t         tab;
    logic signed [63:0] c;
    logic signed [63:0] d;
    logic [63:0]        mag;
    logic [63:0]        q;
    logic [63:0]        cap;
    cap = 64'd2 << FRAC_BITS;
    for (int off = 0; off < TAB_DEPTH; off++) begin
      c = cos_q30(off);
      d = cos_q30(60 - off);
      mag = (c < 0) ? 64'(-c) : 64'(c);
      if (d <= 0) begin
        d = 64'sd1;
      end
      q = ((mag << FRAC_BITS) + 64'(d) / 64'd2) / 64'(d);
      if (q > cap) begin
        q = cap;
      end
      tab[off] = (c < 0) ? RATIO_W'(-q) : RATIO_W'(q);
    end
    return tab;
  endfunction

  localparam ratio_tab_t RATIO_TAB = build_ratio_tab();

endpackage

>>> src/h2r_scale.sv
// One colour channel: intensity scaling, division by 765 and saturation, three stages.
module h2r_scale (
  input  logic                   clk,
  input  logic                   en,
  input  logic [7:0]             intensity,
  input  logic [h2r_pkg::N_W-1:0] num,
  output logic [7:0]             level
);
  import h2r_pkg::*;

  logic [SCALE_W-1:0]   prod;
  logic [X_W-1:0]       x;
  logic [X_W+M_W-1:0]   quot;
  logic                 big;

  assign x = prod[FRAC_BITS +: X_W];

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= SCALE_W'(intensity) * SCALE_W'(num);
      quot  <= (X_W + M_W)'(x) * (X_W + M_W)'(DIV_MUL);
      big   <= (x >= SAT_LIMIT);
      level <= big ? 8'hFF : quot[DIV_SHIFT +: 8];
    end
  end

endmodule

>>> src/hsi_to_rgb_converter.sv
// Top level of the HSI to RGB converter: seven-stage pipeline with valid/stall handshakes.
//
//   Channel | Direction | Payload            | Handshake
//   hsi     | input     | hue, sat, int      | hsi_valid, hsi_stall
//   rgb     | output    | red, green, blue   | rgb_valid, rgb_stall
//
// One transaction is taken every cycle unless rgb is stalled with a result waiting.
// The depth is set by the ratio multiply and the intensity and reciprocal multiplies.
// The whole pipeline holds while rgb is stalled with a result waiting.
// Reset clears the valid bits only; the ratio table is a constant.
module hsi_to_rgb_converter (
  input  logic          clk,
  input  logic          rst,
  input  logic          hsi_valid,
  output logic          hsi_stall,
  input  h2r_pkg::hsi_t hsi,
  output logic          rgb_valid,
  input  logic          rgb_stall,
  output h2r_pkg::rgb_t rgb
);
  import h2r_pkg::*;

  `include "assert_macros.svh"

  localparam int DEPTH = 7;

  logic [DEPTH-1:0] vld;
  logic             adv;

  logic [8:0]  hue_w;
  sector_t     sect_d;
  logic [8:0]  off_w;

  side_t                     side1, side2, side3, side4, side5, side6;
  logic [7:0]                sat1, sat2;
  ratio_t                    ratio1;
  logic signed [PROD_W-1:0]  prod2;
  logic signed [NS_W-1:0]    n2_d, n3_d;
  logic [N_W-1:0]            n1_d;
  logic [N_W-1:0]            num1, num2, num3;
  logic [7:0]                lvl1, lvl2, lvl3;

  assign adv       = !rgb_valid || !rgb_stall;
  assign hsi_stall = !adv;
  assign rgb_valid = vld[DEPTH-1];

  always_comb begin
    hue_w = (hsi.hue >= HUE_WRAP) ? hsi.hue - HUE_WRAP : hsi.hue;
    if (hue_w < SECT_SPAN) begin
      sect_d = SECT_RED;
      off_w  = hue_w;
    end else if (hue_w < SECT_SPAN2) begin
      sect_d = SECT_GREEN;
      off_w  = hue_w - SECT_SPAN;
    end else begin
      sect_d = SECT_BLUE;
      off_w  = hue_w - SECT_SPAN2;
    end
  end

  always_comb begin
    n1_d = N_W'({10'd255 - {2'b00, sat2}, {FRAC_BITS{1'b0}}});
    n2_d = (NS_W'(255) <<< FRAC_BITS) + NS_W'(prod2);
    n3_d = $signed(NS_W'({10'd255 + {2'b00, sat2}, {FRAC_BITS{1'b0}}})) - NS_W'(prod2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], hsi_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1.sector    <= sect_d;
      side1.grey      <= (hsi.saturation == 8'd0);
      side1.intensity <= hsi.intensity;
      sat1            <= hsi.saturation;
      ratio1          <= RATIO_TAB[off_w[6:0]];

      side2 <= side1;
      sat2  <= sat1;
      prod2 <= PROD_W'($signed({1'b0, sat1})) * PROD_W'(ratio1);

      side3 <= side2;
      num1  <= n1_d;
      num2  <= n2_d[NS_W-1] ? '0 : n2_d[N_W-1:0];
      num3  <= n3_d[NS_W-1] ? '0 : n3_d[N_W-1:0];

      side4 <= side3;
      side5 <= side4;
      side6 <= side5;

      if (side6.grey) begin
        rgb <= '{red: side6.intensity, green: side6.intensity, blue: side6.intensity};
      end else begin
        unique case (side6.sector)
          SECT_RED:   rgb <= '{red: lvl2, green: lvl3, blue: lvl1};
          SECT_GREEN: rgb <= '{red: lvl1, green: lvl2, blue: lvl3};
          SECT_BLUE:  rgb <= '{red: lvl3, green: lvl1, blue: lvl2};
          default:    rgb <= '{red: lvl3, green: lvl1, blue: lvl2};
        endcase
      end
    end
  end

  h2r_scale u_scale_low (
    .clk       (clk),
    .en        (adv),
    .intensity (side3.intensity),
    .num       (num1),
    .level     (lvl1)
  );

  h2r_scale u_scale_mid (
    .clk       (clk),
    .en        (adv),
    .intensity (side3.intensity),
    .num       (num2),
    .level     (lvl2)
  );

  h2r_scale u_scale_rest (
    .clk       (clk),
    .en        (adv),
    .intensity (side3.intensity),
    .num       (num3),
    .level     (lvl3)
  );

  `H2R_ASSERT_ALWAYS(a_reset_clears, $past(rst) |-> !rgb_valid, "valid survived reset")
  `H2R_ASSERT(a_shift, $past(adv) && !$past(rst) |-> vld[1] == $past(vld[0]), "valid lost")
  `H2R_ASSERT(a_hold, hsi_stall |=> rgb_valid, "waiting result dropped while stalled")
  `H2R_ASSERT(a_grey, $past(adv && side6.grey) && rgb_valid |-> rgb.red == rgb.blue, "grey mismatch")

endmodule
